// ===== hdl/assert_macros.svh =====
// Assertion macros used by the address cache datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: assertion failed");

// Checks that a condition is never true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rstn, prop)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

// ===== hdl/arpc_pkg.sv =====
// Package with the types and constants of the address cache.
`timescale 1ns / 1ps
package arpc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int ENTRY_W = IP_W + MAC_W;

  localparam int S_TDATA_W = 80;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 48;
  localparam int M_TUSER_W = 2;

  localparam logic REQ_LEARN = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic search;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/arpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module arpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/arpc_ctrl.sv =====
// Controller state machine that sequences accept, search and result of one transaction.
`timescale 1ns / 1ps
module arpc_ctrl
  import arpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status_i.done && status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        cmd_o.finish = status_i.done && status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/arpc_dpath.sv =====
// Datapath with the address table, serial search, fill count and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module arpc_dpath
  import arpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       status_o,
  input  logic             req_type_i,
  input  logic [IP_W-1:0]  ip_addr_i,
  input  logic [MAC_W-1:0] mac_addr_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             hit_o,
  output logic [MAC_W-1:0] mac_out_o,
  output logic             dropped_o
);

  logic             req_type_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic [MAC_W-1:0] found_mac_q;
  logic [MAC_W-1:0] mac_out_q;

  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic             cmp_pend_q, cmp_pend_d;
  logic             found_q, found_d;
  logic             out_valid_q, out_valid_d;
  logic             hit_out_q;
  logic             drop_out_q;

  logic [ENTRY_W-1:0] rd_data;
  logic [IP_W-1:0]    rd_ip;
  logic [MAC_W-1:0]   rd_mac;
  logic               match_now;
  logic               issue;
  logic               table_full;
  logic               learn_new;
  logic               wr_en;

  assign rd_ip  = rd_data[IP_W-1:0];
  assign rd_mac = rd_data[ENTRY_W-1:IP_W];

  assign match_now  = cmp_pend_q && !found_q && (rd_ip == ip_q);
  assign issue      = cmd_i.search && !found_q && !match_now && (rd_idx_q < fill_q);
  assign table_full = (fill_q == CNT_W'(ENTRIES));
  assign learn_new  = (req_type_q == REQ_LEARN) && !found_q;
  assign wr_en      = cmd_i.finish && learn_new && !table_full;

  arpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_q[IDX_W-1:0]),
    .wr_data_i ({mac_q, ip_q}),
    .rd_addr_i (rd_idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  always_comb begin
    rd_idx_d   = rd_idx_q;
    cmp_pend_d = issue;
    found_d    = found_q;
    if (cmd_i.start) begin
      rd_idx_d   = '0;
      cmp_pend_d = 1'b0;
      found_d    = 1'b0;
    end else begin
      if (issue) begin
        rd_idx_d = rd_idx_q + CNT_W'(1);
      end
      if (match_now) begin
        found_d = 1'b1;
      end
    end
  end

  always_comb begin
    fill_d = fill_q;
    if (wr_en) begin
      fill_d = fill_q + CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      cmp_pend_q  <= 1'b0;
      found_q     <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q    <= rd_idx_d;
      cmp_pend_q  <= cmp_pend_d;
      found_q     <= found_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      req_type_q <= req_type_i;
      ip_q       <= ip_addr_i;
      mac_q      <= mac_addr_i;
    end
    if (match_now) begin
      found_mac_q <= rd_mac;
    end
    if (cmd_i.finish) begin
      hit_out_q  <= found_q;
      mac_out_q  <= found_q ? found_mac_q : '0;
      drop_out_q <= learn_new && table_full;
    end
  end

  assign status_o.done     = !cmp_pend_q && (found_q || (rd_idx_q >= fill_q));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_out_q;
  assign mac_out_o   = mac_out_q;
  assign dropped_o   = drop_out_q;

  `ASSERT_AT(a_fill_bounded, clk_i, rst_ni, fill_q <= CNT_W'(ENTRIES))
  `ASSERT_AT(a_fill_steps, clk_i, rst_ni,
             (fill_q == $past(fill_q)) || (fill_q == $past(fill_q) + CNT_W'(1)))
  `ASSERT_NEVER(a_hit_and_drop, clk_i, rst_ni, out_valid_q && hit_out_q && drop_out_q)
  `ASSERT_AT(a_miss_zero_mac, clk_i, rst_ni, (out_valid_q && !hit_out_q) |-> (mac_out_q == '0))

endmodule

// ===== hdl/arp_address_cache.sv =====
// Top level of the IPv4 to MAC address cache.
`timescale 1ns / 1ps
// The cache holds up to ENTRIES address pairs, filled in order of arrival and
// searched one entry per cycle through the single read port of the table RAM.
// Each input transaction is a learn or a lookup and yields exactly one result
// transaction. After acceptance the search reads stored entries in order until
// a match or the last stored entry, so an empty table is not read at all; the
// result is registered once the output is free. A new transaction is accepted
// while the previous result still waits at the output. A learn of an address
// already present keeps the stored MAC and reports a hit, and a learn of a new
// address into a full table stores nothing and reports dropped. The table is
// empty after reset without any clearing pass.
module arp_address_cache
  import arpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // ip_addr, mac_addr
  input  logic [S_TUSER_W-1:0] s_axis_tuser,   // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // mac_out
  output logic [M_TUSER_W-1:0] m_axis_tuser    // hit, dropped
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       hit;
  logic       dropped;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  arpc_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_type_i  (s_axis_tuser[0]),
    .ip_addr_i   (s_axis_tdata[IP_W-1:0]),
    .mac_addr_i  (s_axis_tdata[ENTRY_W-1:IP_W]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .hit_o       (hit),
    .mac_out_o   (m_axis_tdata),
    .dropped_o   (dropped)
  );

  assign m_axis_tuser = {dropped, hit};

endmodule
